FILE: rtl/asnm_pkg.sv
`default_nettype none
package asnm_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_DIV_TND,
        S_WAIT_TND,
        S_DIV_P,
        S_WAIT_P,
        S_HP1,
        S_HP1_W,
        S_HP2,
        S_HP2_W,
        S_LP,
        S_LP_W,
        S_RES,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI
    } t_mul_step;

    // register map, index = byte address / 4
    localparam logic REG_MUTE_MASK = 1'b0;

    localparam int MUTE_P1  = 0;
    localparam int MUTE_P2  = 1;
    localparam int MUTE_TRI = 2;
    localparam int MUTE_NOI = 3;
    localparam int MUTE_DLT = 4;

    localparam int NUM_W  = 50;
    localparam int DEN_W  = 52;
    localparam int NSUM_W = 35;
    localparam int COEF_W = 27;
    localparam int OUT_W  = 24;

    // tnd weights over common denominator 8227*12241*22638
    localparam logic [28:0] MUL_T = 29'(12241 * 22638);
    localparam logic [28:0] MUL_N = 29'(8227 * 22638);
    localparam logic [28:0] MUL_D = 29'(8227 * 12241);

    // divisors are pre-scaled by 4 for the divider
    localparam logic [15:0] NUM_TND_K    = 16'd31958;
    localparam logic [DEN_W-1:0] DEN_TND_BASE =
        DEN_W'(64'd400 * 64'd8227 * 64'd12241 * 64'd22638);
    localparam logic [15:0] NUM_P_K      = 16'd19176;
    localparam logic [DEN_W-1:0] DEN_P_BASE = DEN_W'(64'd400 * 64'd16256);
    localparam logic [15:0] DEN_SUM_K    = 16'd40000;

    localparam logic [COEF_W-1:0] C_HP1 = 27'd133680857;
    localparam logic [COEF_W-1:0] C_HP2 = 27'd132875551;
    localparam logic [COEF_W-1:0] C_LP  = 27'd120661737;

endpackage
`default_nettype wire

FILE: rtl/asnm_if.sv
`default_nettype none
interface asnm_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [3:0] triangle_level;
    logic [3:0] noise_level;
    logic [6:0] delta_level;

    modport source (output valid, pulse1_level, pulse2_level, triangle_level,
                    noise_level, delta_level, input ready);
    modport sink (input valid, pulse1_level, pulse2_level, triangle_level,
                  noise_level, delta_level, output ready);
endinterface

interface asnm_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    logic signed [23:0] mono_sample;

    modport source (output valid, left_sample, right_sample, mono_sample,
                    input ready);
    modport sink (input valid, left_sample, right_sample, mono_sample,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/asnm_div.sv
`default_nettype none
// restoring divider: o_quot = round(num * 2^(QBITS-3) / (den4/4)), half up
module asnm_div #(
    parameter int QBITS = 30
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [asnm_pkg::NUM_W-1:0]    i_num,
    input  wire logic [asnm_pkg::DEN_W-1:0]    i_den4,
    output logic                               o_done,
    output logic [QBITS-2:0]                   o_quot
);
    localparam int CW = $clog2(QBITS + 1);

    logic [asnm_pkg::DEN_W-1:0] r_rem, n_rem;
    logic [asnm_pkg::DEN_W-1:0] r_den;
    logic [QBITS-1:0]           r_q, n_q;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [asnm_pkg::DEN_W-1:0] w_shl;
    logic [QBITS:0]             w_rnd;

    always_comb begin
        w_shl = {r_rem[asnm_pkg::DEN_W-2:0], 1'b0};
        if (w_shl >= r_den) begin
            n_rem = w_shl - r_den;
            n_q   = {r_q[QBITS-2:0], 1'b1};
        end else begin
            n_rem = w_shl;
            n_q   = {r_q[QBITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QBITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(asnm_pkg::DEN_W - asnm_pkg::NUM_W){1'b0}}, i_num};
            r_den <= i_den4;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign w_rnd  = {1'b0, r_q} + (QBITS+1)'(1);
    assign o_quot = w_rnd[QBITS-1:1];
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/asnm_cmul.sv
`default_nettype none
// signed operand times Q0.27 coefficient, magnitude rounded half up,
// two partial products, low half first, then high half
module asnm_cmul #(
    parameter int AW = 34
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [AW-1:0]            i_a,
    input  wire logic [asnm_pkg::COEF_W-1:0]     i_coef,
    output logic                                 o_done,
    output logic signed [AW:0]                   o_prod
);
    localparam int CW  = asnm_pkg::COEF_W;
    localparam int LOW = 25;
    localparam int HW  = AW - LOW;
    localparam int PW  = AW + CW;

    asnm_pkg::t_mul_step r_step, n_step;
    logic [AW-1:0]   r_mag;
    logic            r_neg;
    logic [CW-1:0]   r_coef;
    logic [PW-1:0]   r_acc;
    logic            r_done;
    logic [LOW+CW-1:0] w_lo;
    logic [HW+CW-1:0]  w_hi;
    logic [PW:0]       w_sum;
    logic [AW:0]       w_mag_p;

    assign w_lo = r_mag[LOW-1:0] * r_coef;
    assign w_hi = r_mag[AW-1:LOW] * r_coef;

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            asnm_pkg::MUL_IDLE: if (i_start) n_step = asnm_pkg::MUL_LO;
            asnm_pkg::MUL_LO:   n_step = asnm_pkg::MUL_HI;
            asnm_pkg::MUL_HI:   n_step = asnm_pkg::MUL_IDLE;
            default:            n_step = asnm_pkg::MUL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= asnm_pkg::MUL_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= (r_step == asnm_pkg::MUL_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == asnm_pkg::MUL_IDLE && i_start) begin
            r_neg  <= i_a[AW-1];
            r_mag  <= i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
            r_coef <= i_coef;
        end
        if (r_step == asnm_pkg::MUL_LO) begin
            r_acc <= PW'(w_lo);
        end else if (r_step == asnm_pkg::MUL_HI) begin
            r_acc <= r_acc + (PW'(w_hi) << LOW);
        end
    end

    assign w_sum   = {1'b0, r_acc} + ((PW+1)'(1) << (CW - 1));
    assign w_mag_p = w_sum[PW:CW];
    assign o_prod  = r_neg ? -signed'(w_mag_p) : signed'(w_mag_p);
    assign o_done  = r_done;
endmodule
`default_nettype wire

FILE: rtl/apu_stereo_nonlinear_mixer.sv
`default_nettype none
// Stereo non-linear mixer with output filters. Each request carries five
// channel levels and gives one result of left, right and mono samples
// (signed Q4.19, saturated). Internals are signed Q4.(FILTER_WIDTH-5).
// Each item passes through the shared restoring divider, which runs
// FILTER_WIDTH-2 steps for each of the three mix terms, and through the
// shared coefficient multiplier, used three times per side. Input is not
// ready while an item is at work; a finished result waits in an output
// register. mute_mask is at APB byte address 0.
module apu_stereo_nonlinear_mixer #(
    parameter int FILTER_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    asnm_in_if.sink          i_in,
    asnm_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int W  = FILTER_WIDTH;
    localparam int F  = W - 5;
    localparam int QB = F + 3;
    localparam int AW = W + 2;
    localparam int SW = AW + 2;
    localparam int RS = W - 24;
    localparam int OW = asnm_pkg::OUT_W;

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_MAX)      r = SAT_MAX[W-1:0];
        else if (v < SAT_MIN) r = SAT_MIN[W-1:0];
        else                  r = v[W-1:0];
        return r;
    endfunction

    asnm_pkg::t_state r_state, n_state;

    logic [4:0]  r_mask;
    logic [3:0]  r_p1, r_p2, r_t, r_n;
    logic [6:0]  r_d;
    logic [asnm_pkg::NSUM_W-1:0] r_nsum;
    logic [F+1:0] r_tnd, r_pulse;
    logic         r_side;

    logic signed [W-1:0] r_hp1 [2];
    logic signed [W-1:0] r_pv1 [2];
    logic signed [W-1:0] r_hp2 [2];
    logic signed [W-1:0] r_pv2 [2];
    logic signed [W-1:0] r_lp  [2];
    logic signed [OW-1:0] r_res [2];

    logic                 r_ovalid;
    logic signed [OW-1:0] r_oleft, r_oright, r_omono;

    logic                           w_div_start, w_div_done;
    logic [asnm_pkg::NUM_W-1:0]     w_div_num;
    logic [asnm_pkg::DEN_W-1:0]     w_div_den;
    logic [F+1:0]                   w_quot;
    logic                           w_mul_start, w_mul_done;
    logic signed [AW-1:0]           w_mul_a;
    logic [asnm_pkg::COEF_W-1:0]    w_mul_coef;
    logic signed [AW:0]             w_prod;
    logic [5:0]                     w_psum;
    logic signed [W-1:0]            w_mix;
    logic signed [W-1:0]            w_h_new, w_lp_new;
    logic signed [W:0]              w_lp_ext;
    logic signed [OW:0]             w_rs;
    logic signed [OW-1:0]           w_res;
    logic signed [OW:0]             w_mono_sum;
    logic                           w_in_acc, w_cfg_wr;

    // APB
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == asnm_pkg::REG_MUTE_MASK);
    assign prdata   = (paddr[2] == asnm_pkg::REG_MUTE_MASK) ? {27'd0, r_mask} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mask <= '0;
        else if (w_cfg_wr) r_mask <= pwdata[4:0];
    end

    assign i_in.ready = (r_state == asnm_pkg::S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // mix terms
    assign w_psum = r_side ? (6'(r_p1) + 6'(r_p2) * 6'd3) : (6'(r_p1) * 6'd3 + 6'(r_p2));
    assign w_mix  = W'(r_pulse) + W'(r_tnd);

    always_comb begin
        if (r_state == asnm_pkg::S_DIV_TND) begin
            w_div_num = asnm_pkg::NUM_W'(r_nsum) * asnm_pkg::NUM_W'(asnm_pkg::NUM_TND_K);
            w_div_den = asnm_pkg::DEN_TND_BASE
                      + asnm_pkg::DEN_W'(r_nsum) * asnm_pkg::DEN_W'(asnm_pkg::DEN_SUM_K);
        end else begin
            w_div_num = asnm_pkg::NUM_W'(w_psum) * asnm_pkg::NUM_W'(asnm_pkg::NUM_P_K);
            w_div_den = asnm_pkg::DEN_P_BASE
                      + asnm_pkg::DEN_W'(w_psum) * asnm_pkg::DEN_W'(asnm_pkg::DEN_SUM_K);
        end
    end

    asnm_div #(.QBITS(QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den4  (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    asnm_cmul #(.AW(AW)) u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_coef  (w_mul_coef),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        w_mul_a     = AW'(r_hp1[r_side]) + AW'(w_mix) - AW'(r_pv1[r_side]);
        w_mul_coef  = asnm_pkg::C_HP1;
        unique case (r_state)
            asnm_pkg::S_IDLE:     if (w_in_acc) n_state = asnm_pkg::S_SUM;
            asnm_pkg::S_SUM:      n_state = asnm_pkg::S_DIV_TND;
            asnm_pkg::S_DIV_TND: begin
                w_div_start = 1'b1;
                n_state     = asnm_pkg::S_WAIT_TND;
            end
            asnm_pkg::S_WAIT_TND: if (w_div_done) n_state = asnm_pkg::S_DIV_P;
            asnm_pkg::S_DIV_P: begin
                w_div_start = 1'b1;
                n_state     = asnm_pkg::S_WAIT_P;
            end
            asnm_pkg::S_WAIT_P:   if (w_div_done) n_state = asnm_pkg::S_HP1;
            asnm_pkg::S_HP1: begin
                w_mul_start = 1'b1;
                n_state     = asnm_pkg::S_HP1_W;
            end
            asnm_pkg::S_HP1_W:    if (w_mul_done) n_state = asnm_pkg::S_HP2;
            asnm_pkg::S_HP2: begin
                w_mul_start = 1'b1;
                w_mul_a     = AW'(r_hp2[r_side]) + AW'(r_hp1[r_side]) - AW'(r_pv2[r_side]);
                w_mul_coef  = asnm_pkg::C_HP2;
                n_state     = asnm_pkg::S_HP2_W;
            end
            asnm_pkg::S_HP2_W:    if (w_mul_done) n_state = asnm_pkg::S_LP;
            asnm_pkg::S_LP: begin
                w_mul_start = 1'b1;
                w_mul_a     = AW'(r_hp2[r_side]) - AW'(r_lp[r_side]);
                w_mul_coef  = asnm_pkg::C_LP;
                n_state     = asnm_pkg::S_LP_W;
            end
            asnm_pkg::S_LP_W:     if (w_mul_done) n_state = asnm_pkg::S_RES;
            asnm_pkg::S_RES:      n_state = r_side ? asnm_pkg::S_OUT : asnm_pkg::S_DIV_P;
            asnm_pkg::S_OUT:      if (!r_ovalid || o_out.ready) n_state = asnm_pkg::S_IDLE;
            default:              n_state = asnm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= asnm_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    assign w_h_new  = sat_w(SW'(w_prod));
    assign w_lp_new = sat_w(SW'(r_lp[r_side]) + SW'(w_prod));

    // round to Q4.19, half up
    assign w_lp_ext = {r_lp[r_side][W-1], r_lp[r_side]};
    generate
        if (RS > 0) begin : g_round
            localparam logic signed [W:0] HALF = (W+1)'(1) <<< (RS - 1);
            logic signed [W:0] w_add;
            assign w_add = w_lp_ext + HALF;
            assign w_rs  = (OW+1)'(w_add >>> RS);
        end else begin : g_noround
            assign w_rs = w_lp_ext[OW:0];
        end
    endgenerate

    assign w_res = (w_rs[OW] != w_rs[OW-1])
                 ? {w_rs[OW], {(OW-1){~w_rs[OW]}}} : w_rs[OW-1:0];

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p1 <= r_mask[asnm_pkg::MUTE_P1]  ? 4'd0 : i_in.pulse1_level;
            r_p2 <= r_mask[asnm_pkg::MUTE_P2]  ? 4'd0 : i_in.pulse2_level;
            r_t  <= r_mask[asnm_pkg::MUTE_TRI] ? 4'd0 : i_in.triangle_level;
            r_n  <= r_mask[asnm_pkg::MUTE_NOI] ? 4'd0 : i_in.noise_level;
            r_d  <= r_mask[asnm_pkg::MUTE_DLT] ? 7'd0 : i_in.delta_level;
        end
        if (r_state == asnm_pkg::S_SUM) begin
            r_nsum <= asnm_pkg::NSUM_W'(r_t) * asnm_pkg::NSUM_W'(asnm_pkg::MUL_T)
                    + asnm_pkg::NSUM_W'(r_n) * asnm_pkg::NSUM_W'(asnm_pkg::MUL_N)
                    + asnm_pkg::NSUM_W'(r_d) * asnm_pkg::NSUM_W'(asnm_pkg::MUL_D);
        end
        if (r_state == asnm_pkg::S_WAIT_TND && w_div_done) r_tnd <= w_quot;
        if (r_state == asnm_pkg::S_WAIT_P && w_div_done)   r_pulse <= w_quot;
        if (r_state == asnm_pkg::S_SUM) r_side <= 1'b0;
        else if (r_state == asnm_pkg::S_RES) r_side <= 1'b1;
        if (r_state == asnm_pkg::S_RES) r_res[r_side] <= w_res;
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_hp1[k] <= '0;
                r_pv1[k] <= '0;
                r_hp2[k] <= '0;
                r_pv2[k] <= '0;
                r_lp[k]  <= '0;
            end
        end else begin
            if (r_state == asnm_pkg::S_HP1_W && w_mul_done) begin
                r_hp1[r_side] <= w_h_new;
                r_pv1[r_side] <= w_mix;
            end
            if (r_state == asnm_pkg::S_HP2_W && w_mul_done) begin
                r_hp2[r_side] <= w_h_new;
                r_pv2[r_side] <= r_hp1[r_side];
            end
            if (r_state == asnm_pkg::S_LP_W && w_mul_done) begin
                r_lp[r_side] <= w_lp_new;
            end
        end
    end

    // output register
    assign w_mono_sum = (OW+1)'(r_res[0]) + (OW+1)'(r_res[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == asnm_pkg::S_OUT && (!r_ovalid || o_out.ready)) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == asnm_pkg::S_OUT && (!r_ovalid || o_out.ready)) begin
            r_oleft  <= r_res[0];
            r_oright <= r_res[1];
            r_omono  <= w_mono_sum[OW:1];
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.left_sample  = r_oleft;
    assign o_out.right_sample = r_oright;
    assign o_out.mono_sample  = r_omono;
endmodule
`default_nettype wire

FILE: verif/apu_stereo_nonlinear_mixer_tb.sv
`default_nettype none
module apu_stereo_nonlinear_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 32;
    localparam int FRAC = FW - 5;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [2:0] ADDR_MUTE = {asnm_pkg::REG_MUTE_MASK, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
    localparam longint unsigned K_HP1 = 64'd133680857;
    localparam longint unsigned K_HP2 = 64'd132875551;
    localparam longint unsigned K_LP = 64'd120661737;

    typedef struct packed {
        logic [3:0] pu1;
        logic [3:0] pu2;
        logic [3:0] trg;
        logic [3:0] nse;
        logic [6:0] dmc;
    } t_levels;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic signed [23:0] mono;
    } t_mix_out;

    typedef struct packed {
        t_levels  req;
        bit       typed;
        t_mix_out want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    asnm_in_if in_bus();
    asnm_out_if out_bus();

    apu_stereo_nonlinear_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_bus), .o_out(out_bus),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state, per side: 0 left, 1 right
    logic [4:0] mute_q;
    longint hp1_q[2], hp1_in_q[2], hp2_q[2], hp2_in_q[2], lp_q[2];
    t_mix_out samples_due[$];
    int errors = 0;
    int n_reqs = 0;
    int n_samples = 0;

    localparam t_dir_row DIR_TAB [20] = '{
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 7'd0}, 1'b1, '{24'sd0, 24'sd0, 24'sd0}},
        '{'{4'd15, 4'd15, 4'd15, 4'd15, 7'd127}, 1'b0, '0},
        '{'{4'd15, 4'd15, 4'd15, 4'd15, 7'd127}, 1'b0, '0},
        '{'{4'd15, 4'd0, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd15, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd15, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd15, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 7'd127}, 1'b0, '0},
        '{'{4'd1, 4'd0, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd1, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd1, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd1, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 7'd1}, 1'b0, '0},
        // silent pulse pair, tnd active
        '{'{4'd0, 4'd0, 4'd9, 4'd6, 7'd64}, 1'b0, '0},
        // silent tnd, pulses active
        '{'{4'd7, 4'd12, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'hA, 4'h5, 4'hA, 4'h5, 7'h55}, 1'b0, '0},
        '{'{4'h5, 4'hA, 4'h5, 4'hA, 7'h2A}, 1'b0, '0},
        '{'{4'd15, 4'd15, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 7'd0}, 1'b0, '0},
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 7'd0}, 1'b0, '0}
    };

    localparam logic [31:0] PHASE_MASK [12] = '{
        32'h1F, 32'h01, 32'h02, 32'h04, 32'h08, 32'h10,
        32'hFFFF_FFE3, 32'h00, 32'h15, 32'h0A, 32'h00, 32'h1F
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // round(num * 2^FRAC / den), half up
    function automatic longint unsigned frac_round_div(longint unsigned num,
                                                       longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        if (2 * r >= den) q = q + 1;
        return q;
    endfunction

    // v * c / 2^27, magnitude rounded half away from zero
    function automatic longint coef_scale(longint v, longint unsigned c);
        bit neg;
        longint unsigned m, mh, ml, p;
        neg = v < 0;
        m = neg ? longint'(-v) : longint'(v);
        mh = m >> 27;
        ml = m & ((64'd1 << 27) - 1);
        p = mh * c + ((ml * c + (64'd1 << 26)) >> 27);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint sat_to(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_mix_out mix_and_filter(t_levels r);
        longint unsigned p1, p2, t, n, d, dtot, nsum, tnd, ps, pulse;
        longint mix, h1, h2, side[2], sum;
        t_mix_out o;
        p1 = mute_q[asnm_pkg::MUTE_P1] ? 0 : r.pu1;
        p2 = mute_q[asnm_pkg::MUTE_P2] ? 0 : r.pu2;
        t = mute_q[asnm_pkg::MUTE_TRI] ? 0 : r.trg;
        n = mute_q[asnm_pkg::MUTE_NOI] ? 0 : r.nse;
        d = mute_q[asnm_pkg::MUTE_DLT] ? 0 : r.dmc;
        dtot = 64'd8227 * 64'd12241 * 64'd22638;
        nsum = t * (64'd12241 * 64'd22638) + n * (64'd8227 * 64'd22638)
             + d * (64'd8227 * 64'd12241);
        tnd = frac_round_div(64'd31958 * nsum, 64'd100 * (dtot + 64'd100 * nsum));
        for (int k = 0; k < 2; k++) begin
            ps = (k == 0) ? 3 * p1 + p2 : p1 + 3 * p2;
            pulse = frac_round_div(64'd19176 * ps, 64'd100 * (64'd16256 + 64'd100 * ps));
            mix = longint'(pulse) + longint'(tnd);
            h1 = sat_to(coef_scale(hp1_q[k] + mix - hp1_in_q[k], K_HP1), FW);
            hp1_q[k] = h1;
            hp1_in_q[k] = sat_to(mix, FW);
            h2 = sat_to(coef_scale(hp2_q[k] + h1 - hp2_in_q[k], K_HP2), FW);
            hp2_q[k] = h2;
            hp2_in_q[k] = h1;
            lp_q[k] = sat_to(lp_q[k] + coef_scale(h2 - lp_q[k], K_LP), FW);
            side[k] = sat_to((lp_q[k] + (longint'(1) << (FRAC - 20))) >>> (FRAC - 19), 24);
        end
        sum = side[0] + side[1];
        o.left = side[0][23:0];
        o.right = side[1][23:0];
        o.mono = (sum >>> 1);
        return o;
    endfunction

    function automatic logic [3:0] pick4();
        case ($urandom_range(0, 9))
            0: return 4'd0;
            1: return 4'd15;
            default: return 4'($urandom);
        endcase
    endfunction

    function automatic t_levels rand_levels();
        t_levels r;
        r.pu1 = pick4();
        r.pu2 = pick4();
        r.trg = pick4();
        r.nse = pick4();
        case ($urandom_range(0, 9))
            0: r.dmc = 7'd0;
            1: r.dmc = 7'd127;
            default: r.dmc = 7'($urandom);
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d (sample %0d)",
                 what, $signed(got), $signed(want), n_samples);
    endtask

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(t_levels r, bit typed, t_mix_out typed_want);
        t_mix_out p;
        in_bus.valid = 1'b1;
        in_bus.pulse1_level = r.pu1;
        in_bus.pulse2_level = r.pu2;
        in_bus.triangle_level = r.trg;
        in_bus.noise_level = r.nse;
        in_bus.delta_level = r.dmc;
        do @(posedge i_clk); while (!in_bus.ready);
        p = mix_and_filter(r);
        samples_due.push_back(typed ? typed_want : p);
        n_reqs++;
        @(negedge i_clk);
    endtask

    task automatic apb_xfer(bit wr, logic [2:0] a, logic [31:0] d, output logic [31:0] rd);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = wr;
        paddr = a;
        pwdata = d;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (samples_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_mute(logic [31:0] v);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_MUTE, v, rd);
        mute_q = v[4:0];
        // unmapped address must leave the mask alone
        apb_xfer(1'b1, ADDR_UNMAPPED, ~v, rd);
        apb_xfer(1'b0, ADDR_MUTE, 32'd0, rd);
        if (rd[4:0] !== mute_q) report("mute_mask readback", 24'(rd[4:0]), 24'(mute_q));
    endtask

    task automatic random_burst_run(int count);
        int left_in_burst;
        left_in_burst = 0;
        for (int i = 0; i < count; i++) begin
            if (left_in_burst == 0) begin
                in_bus.valid = 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge i_clk);
                if ($urandom_range(0, 59) == 0)
                    while (samples_due.size() != 0) @(negedge i_clk);
                left_in_burst = $urandom_range(1, 24);
            end
            send_req(rand_levels(), 1'b0, '0);
            left_in_burst--;
        end
        in_bus.valid = 1'b0;
    endtask

    // sink stall pattern: runs of always-ready, coin flips and long holds
    int stall_left = 0;
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_bus.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_bus.ready <= 1'b1;
                1: out_bus.ready <= 1'($urandom_range(0, 1));
                default: begin
                    out_bus.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 40);
                end
            endcase
            if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        t_mix_out w;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (samples_due.size() == 0) begin
                report("unexpected sample", out_bus.left_sample, 24'd0);
            end else begin
                w = samples_due.pop_front();
                if (out_bus.left_sample !== w.left) report("left", out_bus.left_sample, w.left);
                if (out_bus.right_sample !== w.right)
                    report("right", out_bus.right_sample, w.right);
                if (out_bus.mono_sample !== w.mono) report("mono", out_bus.mono_sample, w.mono);
            end
            n_samples++;
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.pulse1_level = '0;
        in_bus.pulse2_level = '0;
        in_bus.triangle_level = '0;
        in_bus.noise_level = '0;
        in_bus.delta_level = '0;
        out_bus.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mute_q = '0;
        for (int k = 0; k < 2; k++) begin
            hp1_q[k] = 0;
            hp1_in_q[k] = 0;
            hp2_q[k] = 0;
            hp2_in_q[k] = 0;
            lp_q[k] = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (DIR_TAB[i]) begin
            send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
            if (i % 4 == 3) begin
                in_bus.valid = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
        end
        in_bus.valid = 1'b0;

        foreach (PHASE_MASK[p]) begin
            drain();
            set_mute(PHASE_MASK[p]);
            random_burst_run(144);
        end

        waited = 0;
        while (samples_due.size() != 0 && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (samples_due.size() != 0) begin
            report("samples never arrived", 24'(samples_due.size()), 24'd0);
        end
        $display("covered %0d requests, %0d samples, %0d mute settings incl. all and none",
                 n_reqs, n_samples, $size(PHASE_MASK) + 1);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
